/* hw/rtl/content_length_deframer_assert.svh */
// ----------------------------------------------------------------------------
// Content-length deframer assertion macros
// Shared concurrent assertion forms, sampled on clk, off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef CONTENT_LENGTH_DEFRAMER_ASSERT_SVH
`define CONTENT_LENGTH_DEFRAMER_ASSERT_SVH

// same-cycle implication
`define CLD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/cld_pkg.sv */
// ----------------------------------------------------------------------------
// Content-length deframer package
// Payload types, codes, sizes and the header key table.
// ----------------------------------------------------------------------------
package cld_pkg;

  localparam int BODY_LENGTH_BITS = 32;
  localparam logic [63:0] COUNTER_MASK = 64'((65'd1 << BODY_LENGTH_BITS) - 65'd1);
  localparam logic [3:0] KEY_LEN = 4'd14;
  localparam logic [3:0] KEY_POS_MAX = 4'd15;

  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_EMPTY   = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic [1:0] ERR_MALFORMED = 2'd0;
  localparam logic [1:0] ERR_MISSING   = 2'd1;
  localparam logic [1:0] ERR_OVER      = 2'd2;

  localparam logic [1:0] LE_OTHER = 2'd0;
  localparam logic [1:0] LE_CR    = 2'd1;
  localparam logic [1:0] LE_LF    = 2'd2;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UZ    = 8'h5a;
  localparam logic [7:0] CASE_GAP = 8'h20;

  typedef enum logic [1:0] {
    PH_HEADER = 2'd0,
    PH_BODY   = 2'd1,
    PH_HALT   = 2'd2
  } cld_phase_t;

  typedef enum logic [1:0] {
    LN_KEY    = 2'd0,
    LN_BLANK  = 2'd1,
    LN_DIGITS = 2'd2,
    LN_REST   = 2'd3
  } cld_line_t;

  typedef struct packed {
    logic [7:0] stream_byte;
    logic       new_stream;
  } cld_in_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [7:0] payload_byte;
    logic       last_of_frame;
    logic [1:0] fault_code;
  } cld_out_t;

  typedef struct packed {
    logic [7:0] raw;
    logic [7:0] lower;
    logic [3:0] digit;
    logic [1:0] line_code;
    logic       is_digit;
    logic       is_colon;
    logic       is_blank;
    logic       new_stream;
  } cld_class_t;

  function automatic logic [7:0] key_char(input logic [3:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = 8'h63; // c
      4'd1:    c = 8'h6f; // o
      4'd2:    c = 8'h6e; // n
      4'd3:    c = 8'h74; // t
      4'd4:    c = 8'h65; // e
      4'd5:    c = 8'h6e; // n
      4'd6:    c = 8'h74; // t
      4'd7:    c = 8'h2d; // -
      4'd8:    c = 8'h6c; // l
      4'd9:    c = 8'h65; // e
      4'd10:   c = 8'h6e; // n
      4'd11:   c = 8'h67; // g
      4'd12:   c = 8'h74; // t
      4'd13:   c = 8'h68; // h
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/cld_front.sv */
// ----------------------------------------------------------------------------
// Content-length deframer front end
// Classifies each incoming byte for the header parser.
// ----------------------------------------------------------------------------
module cld_front
  import cld_pkg::*;
(
  input  cld_in_t    in_item,
  output cld_class_t cls
);

  logic [7:0] b;

  assign b = in_item.stream_byte;

  always_comb begin
    cls.raw        = b;
    cls.lower      = (b >= CH_UA && b <= CH_UZ) ? (b + CASE_GAP) : b;
    cls.digit      = 4'(b - CH_ZERO);
    cls.is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    cls.is_colon   = (b == CH_COLON);
    cls.is_blank   = (b == CH_SPACE) || (b == CH_TAB);
    cls.new_stream = in_item.new_stream;
    if (b == CH_CR) begin
      cls.line_code = LE_CR;
    end else if (b == CH_LF) begin
      cls.line_code = LE_LF;
    end else begin
      cls.line_code = LE_OTHER;
    end
  end

endmodule

/* hw/rtl/cld_fifo.sv */
// ----------------------------------------------------------------------------
// Content-length deframer item queue
// Short queue of classified bytes between front end and parser.
// ----------------------------------------------------------------------------
module cld_fifo
  import cld_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_en,
  input  cld_class_t wr_data,
  output logic       is_full,
  input  logic       rd_en,
  output logic       rd_valid,
  output cld_class_t rd_data
);

  cld_class_t         mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign is_full  = (count_r == CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !rd_en) begin
      count_nxt = count_r + 1'b1;
    end else if (rd_en && !wr_en) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

/* hw/rtl/cld_back.sv */
// ----------------------------------------------------------------------------
// Content-length deframer parser
// Header parse, length check and body framing; one registered result slot.
// ----------------------------------------------------------------------------
module cld_back
  import cld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [31:0] max_payload_len,
  input  logic        item_valid,
  input  cld_class_t  item,
  output logic        item_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output cld_out_t    out_result
);

`include "content_length_deframer_assert.svh"

  cld_phase_t                  phase_r, phase_nxt;
  logic [5:0]                  rle_r, rle_nxt;
  logic [3:0]                  kpos_r, kpos_nxt;
  cld_line_t                   line_r, line_nxt;
  logic                        kmatch_r, kmatch_nxt;
  logic [63:0]                 acc_r, acc_nxt;
  logic                        seen_r, seen_nxt;
  logic                        found_r, found_nxt;
  logic [63:0]                 decl_r, decl_nxt;
  logic                        malf_r, malf_nxt;
  logic [BODY_LENGTH_BITS-1:0] rem_r, rem_nxt;

  logic     out_valid_r;
  cld_out_t out_data_r;
  logic     go;
  logic     res_valid;
  cld_out_t res;

  assign go         = item_valid && (!out_valid_r || out_pop);
  assign item_pop   = go;
  assign out_empty  = !out_valid_r;
  assign out_result = out_data_r;

  always_comb begin : parse
    logic [67:0] prod;
    logic [1:0]  p1;
    logic [1:0]  p2;
    logic [1:0]  p3;
    logic        term;
    logic [63:0] lim;
    logic        err_hit;
    logic [1:0]  err;

    phase_nxt  = phase_r;
    rle_nxt    = rle_r;
    kpos_nxt   = kpos_r;
    line_nxt   = line_r;
    kmatch_nxt = kmatch_r;
    acc_nxt    = acc_r;
    seen_nxt   = seen_r;
    found_nxt  = found_r;
    decl_nxt   = decl_r;
    malf_nxt   = malf_r;
    rem_nxt    = rem_r;
    res_valid  = 1'b0;
    res        = '0;
    prod       = '0;
    p1         = rle_r[1:0];
    p2         = rle_r[3:2];
    p3         = rle_r[5:4];
    term       = 1'b0;
    lim        = '0;
    err_hit    = 1'b0;
    err        = ERR_MALFORMED;

    if (go) begin
      if (item.new_stream) begin
        phase_nxt  = PH_HEADER;
        rle_nxt    = '0;
        kpos_nxt   = '0;
        line_nxt   = LN_KEY;
        kmatch_nxt = 1'b1;
        acc_nxt    = '0;
        seen_nxt   = 1'b0;
        found_nxt  = 1'b0;
        decl_nxt   = '0;
        malf_nxt   = 1'b0;
        rem_nxt    = '0;
        p1         = LE_OTHER;
        p2         = LE_OTHER;
        p3         = LE_OTHER;
      end

      case (phase_nxt)
        PH_BODY: begin
          rem_nxt                = rem_nxt - 1'b1;
          res_valid              = 1'b1;
          res.result_kind        = KIND_PAYLOAD;
          res.payload_byte       = item.raw;
          res.last_of_frame      = (rem_nxt == '0);
          if (rem_nxt == '0) begin
            phase_nxt  = PH_HEADER;
            rle_nxt    = '0;
            kpos_nxt   = '0;
            line_nxt   = LN_KEY;
            kmatch_nxt = 1'b1;
            acc_nxt    = '0;
            seen_nxt   = 1'b0;
            found_nxt  = 1'b0;
            decl_nxt   = '0;
            malf_nxt   = 1'b0;
          end
        end
        PH_HEADER: begin
          rle_nxt = {rle_nxt[3:0], item.line_code};
          if (item.line_code == LE_OTHER) begin
            prod = ({4'd0, acc_nxt} << 3) + ({4'd0, acc_nxt} << 1) + 68'(item.digit);
            case (line_nxt)
              LN_KEY: begin
                if (item.is_colon) begin
                  kmatch_nxt = kmatch_nxt && (kpos_nxt == KEY_LEN);
                  line_nxt   = LN_BLANK;
                end else begin
                  if (kpos_nxt >= KEY_LEN || item.lower != key_char(kpos_nxt)) begin
                    kmatch_nxt = 1'b0;
                  end
                  if (kpos_nxt < KEY_POS_MAX) begin
                    kpos_nxt = kpos_nxt + 1'b1;
                  end
                end
              end
              LN_BLANK, LN_DIGITS: begin
                if (line_nxt == LN_BLANK && item.is_blank) begin
                  line_nxt = LN_BLANK;
                end else if (!item.is_digit) begin
                  line_nxt = LN_REST;
                end else if (prod[67:64] != '0) begin
                  if (kmatch_nxt) begin
                    malf_nxt = 1'b1;
                  end
                  kmatch_nxt = 1'b0;
                  line_nxt   = LN_REST;
                end else begin
                  line_nxt = LN_DIGITS;
                  acc_nxt  = prod[63:0];
                  seen_nxt = 1'b1;
                end
              end
              default: begin
                line_nxt = LN_REST;
              end
            endcase
          end else begin
            // end of line
            if (line_nxt != LN_KEY && kmatch_nxt) begin
              if (!seen_nxt) begin
                malf_nxt = 1'b1;
              end else begin
                decl_nxt  = acc_nxt;
                found_nxt = 1'b1;
              end
            end
            kpos_nxt   = '0;
            line_nxt   = LN_KEY;
            kmatch_nxt = 1'b1;
            acc_nxt    = '0;
            seen_nxt   = 1'b0;

            term = (item.line_code == LE_LF) &&
                   (p1 == LE_LF || (p1 == LE_CR && p2 == LE_LF && p3 == LE_CR));
            if (term) begin
              lim = (64'(max_payload_len) > COUNTER_MASK) ? COUNTER_MASK
                                                          : 64'(max_payload_len);
              if (malf_nxt) begin
                err_hit = 1'b1;
                err     = ERR_MALFORMED;
              end else if (!found_nxt) begin
                err_hit = 1'b1;
                err     = ERR_MISSING;
              end else if (decl_nxt > lim) begin
                err_hit = 1'b1;
                err     = ERR_OVER;
              end
              if (err_hit) begin
                phase_nxt       = PH_HALT;
                res_valid       = 1'b1;
                res.result_kind = KIND_ERROR;
                res.fault_code  = err;
              end else if (decl_nxt == '0) begin
                rle_nxt           = '0;
                found_nxt         = 1'b0;
                malf_nxt          = 1'b0;
                rem_nxt           = '0;
                res_valid         = 1'b1;
                res.result_kind   = KIND_EMPTY;
                res.last_of_frame = 1'b1;
              end else begin
                rem_nxt   = decl_nxt[BODY_LENGTH_BITS-1:0];
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        default: begin
          phase_nxt = phase_nxt;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      rle_r       <= '0;
      kpos_r      <= '0;
      line_r      <= LN_KEY;
      kmatch_r    <= 1'b1;
      acc_r       <= '0;
      seen_r      <= 1'b0;
      found_r     <= 1'b0;
      decl_r      <= '0;
      malf_r      <= 1'b0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      rle_r    <= rle_nxt;
      kpos_r   <= kpos_nxt;
      line_r   <= line_nxt;
      kmatch_r <= kmatch_nxt;
      acc_r    <= acc_nxt;
      seen_r   <= seen_nxt;
      found_r  <= found_nxt;
      decl_r   <= decl_nxt;
      malf_r   <= malf_nxt;
      rem_r    <= rem_nxt;
      if (go && res_valid) begin
        out_valid_r <= 1'b1;
      end else if (out_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go && res_valid) begin
      out_data_r <= res;
    end
  end

  `CLD_ASSERT_IMP(a_kind_legal, out_valid_r,
    out_data_r.result_kind == KIND_PAYLOAD || out_data_r.result_kind == KIND_EMPTY || out_data_r.result_kind == KIND_ERROR,
    "illegal result kind")
  `CLD_ASSERT_IMP(a_error_clean, out_valid_r && out_data_r.result_kind == KIND_ERROR,
    out_data_r.payload_byte == '0 && !out_data_r.last_of_frame,
    "error result carries payload")
  `CLD_ASSERT_IMP(a_nonerror_code, out_valid_r && out_data_r.result_kind != KIND_ERROR,
    out_data_r.fault_code == ERR_MALFORMED,
    "error code set on non-error result")
  `CLD_ASSERT_NEXT(a_body_emits, go && phase_r == PH_BODY && !item.new_stream,
    out_valid_r && out_data_r.result_kind == KIND_PAYLOAD,
    "body byte produced no result")
  `CLD_ASSERT_NEXT(a_halt_holds, phase_r == PH_HALT && !(go && item.new_stream),
    phase_r == PH_HALT,
    "left halt without new stream")

endmodule

/* hw/rtl/content_length_deframer.sv */
// ----------------------------------------------------------------------------
// Content-length deframer
// A pushed byte is written to the queue, parsed, and any result registered.
// One byte per cycle while the result slot is free or being popped.
// Reset: synchronous active-low rst_n empties the queue and result slot,
// restarts header parsing and sets max_payload_len to 1048576.
// ----------------------------------------------------------------------------
module content_length_deframer
  import cld_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  cld_in_t     in_data,
  output logic        empty,
  input  logic        pop,
  output cld_out_t    out_data,
  input  logic        valid,
  output logic        ready,
  input  logic [31:0] cfg_max_payload_len
);

  logic [31:0] max_len_r;
  cld_class_t  cls;
  cld_class_t  q_data;
  logic        q_valid;
  logic        q_pop;
  logic        q_full;

  assign ready = 1'b1;
  assign full  = q_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 32'd1048576;
    end else if (valid && ready) begin
      max_len_r <= cfg_max_payload_len;
    end
  end

  cld_front u_front (
    .in_item (in_data),
    .cls     (cls)
  );

  cld_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (push && !q_full),
    .wr_data  (cls),
    .is_full  (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_data  (q_data)
  );

  cld_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .max_payload_len (max_len_r),
    .item_valid      (q_valid),
    .item            (q_data),
    .item_pop        (q_pop),
    .out_empty       (empty),
    .out_pop         (pop),
    .out_result      (out_data)
  );

endmodule
